[src/tas_pkg.sv]
// ----------------------------------------------------------------------------
// tas_pkg: thermal alarm sequencer shared types and constants
// Register map, reset values, phase codes and the structs passed between the
// configuration bank, the sequencer core and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tas_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DataW   = 8;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_GREEN_BELOW   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_YELLOW_BELOW  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RED_MAX       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TRIP_TICKS    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_TICKS = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SERVO_REST    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SERVO_TRIP    = 3'd6;

  // Register reset values
  localparam logic [DataW-1:0] RST_GREEN_BELOW   = 8'd20;
  localparam logic [DataW-1:0] RST_YELLOW_BELOW  = 8'd40;
  localparam logic [DataW-1:0] RST_RED_MAX       = 8'd50;
  localparam logic [DataW-1:0] RST_TRIP_TICKS    = 8'd7;
  localparam logic [DataW-1:0] RST_RELEASE_TICKS = 8'd13;
  localparam logic [DataW-1:0] RST_SERVO_REST    = 8'd124;
  localparam logic [DataW-1:0] RST_SERVO_TRIP    = 8'd187;

  // Link codes
  localparam logic [DataW-1:0] READY_CODE = 8'd1;
  localparam logic [DataW-1:0] STOP_CODE  = 8'd1;

  // Event kinds
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Lamp codes
  localparam logic [1:0] LAMP_NONE   = 2'd0;
  localparam logic [1:0] LAMP_GREEN  = 2'd1;
  localparam logic [1:0] LAMP_YELLOW = 2'd2;
  localparam logic [1:0] LAMP_RED    = 2'd3;

  typedef enum logic [2:0] {
    PH_WAIT_RDY   = 3'd0,
    PH_READ_TEMP  = 3'd1,
    PH_WAIT_STOP  = 3'd2,
    PH_READ_STOP  = 3'd3,
    PH_EMRG_WAIT  = 3'd4,
    PH_EMRG_TEMP  = 3'd5,
    PH_HOLD       = 3'd6
  } phase_e;

  typedef struct packed {
    logic [DataW-1:0] green_below;
    logic [DataW-1:0] yellow_below;
    logic [DataW-1:0] red_max;
    logic [DataW-1:0] trip_ticks;
    logic [DataW-1:0] release_ticks;
    logic [DataW-1:0] servo_rest;
    logic [DataW-1:0] servo_trip;
  } cfg_t;

  typedef struct packed {
    logic             send_ready;
    logic [1:0]       lamp;
    logic             motor_stop;
    logic             buzz_level;
    logic [DataW-1:0] servo_position;
    logic [2:0]       phase_now;
  } res_t;

endpackage

`default_nettype wire

[src/thermal_alarm_sequencer_top.sv]
// ----------------------------------------------------------------------------
// thermal_alarm_sequencer_top: thermal alarm sequencer
// Takes link bytes and one-second ticks, runs the ready handshake, lights the
// temperature lamp and drives buzzer, motor stop and servo through the
// emergency trip and hold sequence.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake              payload
//   -------   ---------   --------------------   ------------------------------
//   in        sink        in_valid_i/in_stall_o  in_cmd_i, in_rx_byte_i
//   out       source      out_valid_o/out_stall_i send_ready, lamp, motor_stop,
//                                                buzz_level, servo_position,
//                                                phase_now
//   cfg       sink        cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// Every item produces exactly one result. It is captured in the input
// register, then passes through the sequencer logic into the result
// register, from which its result is offered. One item is accepted per
// cycle while in_stall_o is low. A stall holds the result register, then
// the input register; in_stall_o rises only once both hold an item. Reset
// clears the state and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module thermal_alarm_sequencer_top #(
  parameter int unsigned TICK_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [tas_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tas_pkg::DataW-1:0]    cfg_wdata_i,
  // event channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         in_cmd_i,
  input  logic [tas_pkg::DataW-1:0]    in_rx_byte_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         out_send_ready_o,
  output logic [1:0]                   out_lamp_o,
  output logic                         out_motor_stop_o,
  output logic                         out_buzz_level_o,
  output logic [tas_pkg::DataW-1:0]    out_servo_position_o,
  output logic [2:0]                   out_phase_now_o
);
  import tas_pkg::*;

  cfg_t             cfg;
  res_t             res, res_q;
  logic             s1_valid_q, out_valid_q;
  logic             s1_cmd_q;
  logic [DataW-1:0] s1_byte_q;
  logic             advance, load_s1, fire;

  tas_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Result register frees up when empty or when its item is taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && advance;
  assign load_s1    = !s1_valid_q || advance;
  assign in_stall_o = !load_s1;

  tas_core #(
    .TICK_BITS (TICK_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .fire_i    (fire),
    .ev_cmd_i  (s1_cmd_q),
    .ev_byte_i (s1_byte_q),
    .res_o     (res)
  );

  // Input register: control resets, payload does not
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (load_s1) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_s1 && in_valid_i) begin
      s1_cmd_q  <= in_cmd_i;
      s1_byte_q <= in_rx_byte_i;
    end
  end

  // Result register: hold while stalled, advance otherwise
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_send_ready_o     = res_q.send_ready;
  assign out_lamp_o           = res_q.lamp;
  assign out_motor_stop_o     = res_q.motor_stop;
  assign out_buzz_level_o     = res_q.buzz_level;
  assign out_servo_position_o = res_q.servo_position;
  assign out_phase_now_o      = res_q.phase_now;

endmodule

`default_nettype wire

[src/tas_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tas_cfg_regs: configuration register bank
// Seven 8-bit registers written through a plain write port; unknown indexes
// are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module tas_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tas_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tas_pkg::DataW-1:0]    cfg_wdata_i,
  output tas_pkg::cfg_t                cfg_o
);
  import tas_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GREEN_BELOW:   cfg_d.green_below   = cfg_wdata_i;
        CFG_YELLOW_BELOW:  cfg_d.yellow_below  = cfg_wdata_i;
        CFG_RED_MAX:       cfg_d.red_max       = cfg_wdata_i;
        CFG_TRIP_TICKS:    cfg_d.trip_ticks    = cfg_wdata_i;
        CFG_RELEASE_TICKS: cfg_d.release_ticks = cfg_wdata_i;
        CFG_SERVO_REST:    cfg_d.servo_rest    = cfg_wdata_i;
        CFG_SERVO_TRIP:    cfg_d.servo_trip    = cfg_wdata_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.green_below   <= RST_GREEN_BELOW;
      cfg_q.yellow_below  <= RST_YELLOW_BELOW;
      cfg_q.red_max       <= RST_RED_MAX;
      cfg_q.trip_ticks    <= RST_TRIP_TICKS;
      cfg_q.release_ticks <= RST_RELEASE_TICKS;
      cfg_q.servo_rest    <= RST_SERVO_REST;
      cfg_q.servo_trip    <= RST_SERVO_TRIP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[src/tas_core.sv]
// ----------------------------------------------------------------------------
// tas_core: sequencer state and next-state logic
// Holds phase, tick count, lamp, buzzer and servo; computes the result of one
// event and commits the new state when the event fires.
// ----------------------------------------------------------------------------
`default_nettype none

module tas_core #(
  parameter int unsigned TICK_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tas_pkg::cfg_t              cfg_i,
  input  logic                       fire_i,
  input  logic                       ev_cmd_i,
  input  logic [tas_pkg::DataW-1:0]  ev_byte_i,
  output tas_pkg::res_t              res_o
);
  import tas_pkg::*;

  localparam int unsigned CmpW = (TICK_BITS > DataW) ? TICK_BITS : DataW;
  localparam logic [TICK_BITS-1:0] TickMax = {TICK_BITS{1'b1}};

  phase_e               phase_q, phase_d;
  logic [TICK_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic [1:0]           lamp_q, lamp_d;
  logic                 buzz_q, buzz_d;
  logic [DataW-1:0]     servo_q, servo_d;
  logic                 ready, stop;
  logic                 cnt_ge_trip, inc_ge_release;

  assign cnt_inc        = (cnt_q != TickMax) ? cnt_q + 1'b1 : cnt_q;
  assign cnt_ge_trip    = CmpW'(cnt_q) >= CmpW'(cfg_i.trip_ticks);
  assign inc_ge_release = CmpW'(cnt_inc) >= CmpW'(cfg_i.release_ticks);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    lamp_d  = lamp_q;
    buzz_d  = buzz_q;
    servo_d = servo_q;
    ready   = 1'b0;
    stop    = 1'b0;
    if (ev_cmd_i == CMD_TICK) begin
      // Timer runs only in the emergency phases
      if (phase_q == PH_EMRG_WAIT || phase_q == PH_EMRG_TEMP || phase_q == PH_HOLD) begin
        cnt_d = cnt_inc;
        if (phase_q == PH_HOLD && inc_ge_release) begin
          cnt_d   = '0;
          buzz_d  = 1'b0;
          servo_d = cfg_i.servo_rest;
          phase_d = PH_WAIT_RDY;
        end
      end
    end else begin
      unique case (phase_q)
        PH_WAIT_RDY, PH_WAIT_STOP, PH_EMRG_WAIT: begin
          if (ev_byte_i == READY_CODE) begin
            ready   = 1'b1;
            phase_d = phase_e'(phase_q + 3'd1);
          end
        end
        PH_READ_TEMP: begin
          if (ev_byte_i < cfg_i.green_below) begin
            lamp_d  = LAMP_GREEN;
            phase_d = PH_WAIT_RDY;
          end else if (ev_byte_i < cfg_i.yellow_below) begin
            lamp_d  = LAMP_YELLOW;
            phase_d = PH_WAIT_RDY;
          end else if (ev_byte_i <= cfg_i.red_max) begin
            lamp_d  = LAMP_RED;
            phase_d = PH_WAIT_STOP;
          end else begin
            lamp_d  = LAMP_RED;
            buzz_d  = 1'b1;
            cnt_d   = '0;
            phase_d = PH_EMRG_WAIT;
          end
        end
        PH_READ_STOP: begin
          stop    = (ev_byte_i == STOP_CODE);
          phase_d = PH_WAIT_RDY;
        end
        PH_EMRG_TEMP: begin
          if (cnt_ge_trip) begin
            stop    = 1'b1;
            servo_d = cfg_i.servo_trip;
            phase_d = PH_HOLD;
            // Release at once when the count already reached the release value
            if (CmpW'(cnt_q) >= CmpW'(cfg_i.release_ticks)) begin
              cnt_d   = '0;
              buzz_d  = 1'b0;
              servo_d = cfg_i.servo_rest;
              phase_d = PH_WAIT_RDY;
            end
          end else if (ev_byte_i > cfg_i.red_max) begin
            phase_d = PH_EMRG_WAIT;
          end else begin
            cnt_d   = '0;
            buzz_d  = 1'b0;
            servo_d = cfg_i.servo_rest;
            phase_d = PH_WAIT_RDY;
          end
        end
        PH_HOLD: phase_d = phase_q;
        default: phase_d = PH_WAIT_RDY;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT_RDY;
      cnt_q   <= '0;
      lamp_q  <= LAMP_NONE;
      buzz_q  <= 1'b0;
      servo_q <= RST_SERVO_REST;
    end else if (fire_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      lamp_q  <= lamp_d;
      buzz_q  <= buzz_d;
      servo_q <= servo_d;
    end
  end

  assign res_o.send_ready     = ready;
  assign res_o.lamp           = lamp_d;
  assign res_o.motor_stop     = stop;
  assign res_o.buzz_level     = buzz_d;
  assign res_o.servo_position = servo_d;
  assign res_o.phase_now      = phase_d;

endmodule

`default_nettype wire

[src/tas_checker.sv]
// ----------------------------------------------------------------------------
// tas_checker: port-level checks for the thermal alarm sequencer
// Watches the result channel for handshake and sequencing consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module tas_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       out_send_ready_o,
  input logic [1:0] out_lamp_o,
  input logic       out_motor_stop_o,
  input logic       out_buzz_level_o,
  input logic [2:0] out_phase_now_o
);
  import tas_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_phase_now_o)
      && $stable(out_motor_stop_o) && $stable(out_send_ready_o))
    else $error("stalled result changed");

  // Ready answer always moves into a read phase
  a_ready_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_send_ready_o |->
      out_phase_now_o == PH_READ_TEMP || out_phase_now_o == PH_READ_STOP
      || out_phase_now_o == PH_EMRG_TEMP)
    else $error("ready sent outside a handshake");

  // Motor stop lands in wait-ready or hold
  a_stop_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_motor_stop_o |->
      out_phase_now_o == PH_WAIT_RDY || out_phase_now_o == PH_HOLD)
    else $error("motor stop in unexpected phase");

  // Emergency phases keep buzzer on and lamp red
  a_emrg_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_phase_now_o == PH_EMRG_WAIT || out_phase_now_o == PH_EMRG_TEMP
      || out_phase_now_o == PH_HOLD) |-> out_buzz_level_o && out_lamp_o == LAMP_RED)
    else $error("emergency without alarm");

endmodule

bind thermal_alarm_sequencer_top tas_checker u_tas_checker (.*);

`default_nettype wire

[test/tas_result_checker.sv]
// ----------------------------------------------------------------------------
// tas_result_checker: result prediction and comparison for the sequencer
// Follows register writes and accepted events, predicts each result from its
// own copy of the sequencer state and compares every accepted result, field
// by field, against the oldest prediction still due.
// ----------------------------------------------------------------------------
module tas_result_checker #(
  parameter int unsigned TICK_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tas_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tas_pkg::DataW-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         in_cmd_i,
  input  logic [tas_pkg::DataW-1:0]    in_rx_byte_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic                         out_send_ready_i,
  input  logic [1:0]                   out_lamp_i,
  input  logic                         out_motor_stop_i,
  input  logic                         out_buzz_level_i,
  input  logic [tas_pkg::DataW-1:0]    out_servo_position_i,
  input  logic [2:0]                   out_phase_now_i,
  output int unsigned                  results_due_o,
  output int unsigned                  mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import tas_pkg::*;

  localparam logic [TICK_BITS-1:0] TickTop = '1;

  cfg_t                 regs;
  phase_e               phase_q;
  logic [TICK_BITS-1:0] ticks_q;
  logic [1:0]           lamp_q;
  logic                 buzzer_q;
  logic [DataW-1:0]     servo_q;
  res_t                 due_results [$];
  int unsigned          mismatch_cnt = 0;

  assign mismatches_o = mismatch_cnt;

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    mismatch_cnt++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    end
  endtask

  task automatic clear_emergency();
    ticks_q  = '0;
    buzzer_q = 1'b0;
    servo_q  = regs.servo_rest;
    phase_q  = PH_WAIT_RDY;
  endtask

  task automatic step_sequencer(input logic cmd, input logic [DataW-1:0] b, output res_t r);
    logic ready;
    logic stop;
    ready = 1'b0;
    stop  = 1'b0;
    if (cmd == CMD_TICK) begin
      // the timer runs only through the emergency and the hold
      if (phase_q inside {PH_EMRG_WAIT, PH_EMRG_TEMP, PH_HOLD}) begin
        if (ticks_q != TickTop) ticks_q++;
        if (phase_q == PH_HOLD && ticks_q >= regs.release_ticks) clear_emergency();
      end
    end else begin
      case (phase_q)
        PH_WAIT_RDY, PH_WAIT_STOP, PH_EMRG_WAIT: begin
          if (b == READY_CODE) begin
            ready   = 1'b1;
            phase_q = phase_q.next();
          end
        end
        PH_READ_TEMP: begin
          if (b < regs.green_below) begin
            lamp_q  = LAMP_GREEN;
            phase_q = PH_WAIT_RDY;
          end else if (b < regs.yellow_below) begin
            lamp_q  = LAMP_YELLOW;
            phase_q = PH_WAIT_RDY;
          end else if (b <= regs.red_max) begin
            lamp_q  = LAMP_RED;
            phase_q = PH_WAIT_STOP;
          end else begin
            lamp_q   = LAMP_RED;
            buzzer_q = 1'b1;
            ticks_q  = '0;
            phase_q  = PH_EMRG_WAIT;
          end
        end
        PH_READ_STOP: begin
          stop    = (b == STOP_CODE);
          phase_q = PH_WAIT_RDY;
        end
        PH_EMRG_TEMP: begin
          if (ticks_q >= regs.trip_ticks) begin
            servo_q = regs.servo_trip;
            stop    = 1'b1;
            phase_q = PH_HOLD;
            if (ticks_q >= regs.release_ticks) clear_emergency();
          end else if (b > regs.red_max) begin
            phase_q = PH_EMRG_WAIT;
          end else begin
            clear_emergency();
          end
        end
        PH_HOLD: begin
        end
        default: begin
          phase_q = PH_WAIT_RDY;
        end
      endcase
    end
    r = '{send_ready: ready, lamp: lamp_q, motor_stop: stop, buzz_level: buzzer_q,
          servo_position: servo_q, phase_now: phase_q};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    res_t got_res;
    res_t want_res;
    if (!rst_ni) begin
      regs = '{green_below: RST_GREEN_BELOW, yellow_below: RST_YELLOW_BELOW,
               red_max: RST_RED_MAX, trip_ticks: RST_TRIP_TICKS,
               release_ticks: RST_RELEASE_TICKS, servo_rest: RST_SERVO_REST,
               servo_trip: RST_SERVO_TRIP};
      phase_q  = PH_WAIT_RDY;
      ticks_q  = '0;
      lamp_q   = LAMP_NONE;
      buzzer_q = 1'b0;
      servo_q  = RST_SERVO_REST;
      due_results.delete();
      results_due_o <= 0;
    end else begin
      // compare before predicting so that a result can never match its own item
      if (out_valid_i && !out_stall_i) begin
        got_res = '{send_ready: out_send_ready_i, lamp: out_lamp_i,
                    motor_stop: out_motor_stop_i, buzz_level: out_buzz_level_i,
                    servo_position: out_servo_position_i, phase_now: out_phase_now_i};
        if (due_results.size() == 0) begin
          report_mismatch("result arrived with nothing due");
        end else begin
          want_res = due_results.pop_front();
          check_field("send_ready", got_res.send_ready, want_res.send_ready);
          check_field("lamp", got_res.lamp, want_res.lamp);
          check_field("motor_stop", got_res.motor_stop, want_res.motor_stop);
          check_field("buzz_level", got_res.buzz_level, want_res.buzz_level);
          check_field("servo_position", got_res.servo_position, want_res.servo_position);
          check_field("phase_now", got_res.phase_now, want_res.phase_now);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GREEN_BELOW:   regs.green_below   = cfg_wdata_i;
          CFG_YELLOW_BELOW:  regs.yellow_below  = cfg_wdata_i;
          CFG_RED_MAX:       regs.red_max       = cfg_wdata_i;
          CFG_TRIP_TICKS:    regs.trip_ticks    = cfg_wdata_i;
          CFG_RELEASE_TICKS: regs.release_ticks = cfg_wdata_i;
          CFG_SERVO_REST:    regs.servo_rest    = cfg_wdata_i;
          CFG_SERVO_TRIP:    regs.servo_trip    = cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        step_sequencer(in_cmd_i, in_rx_byte_i, want_res);
        due_results.push_back(want_res);
      end
      results_due_o <= due_results.size();
    end
  end

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: thermal alarm sequencer testbench
// Resets the sequencer, walks it through a short opening script, then feeds
// randomized handshakes, band readings and emergency runs under a series of
// register settings, with random sender gaps and receiver stalls. A checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tas_pkg::*;

  localparam int unsigned TickBits   = 8;
  // give the pipeline time to settle before a write or the verdict
  localparam int unsigned CfgSettle  = 4;
  localparam int unsigned DrainWait  = 10;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned ItemGoal   = 1350;
  localparam int unsigned PhaseItems = 150;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i    = '0;
  logic [DataW-1:0]    cfg_wdata_i  = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_cmd_i     = CMD_BYTE;
  logic [DataW-1:0]    in_rx_byte_i = '0;
  logic                out_stall_i  = 1'b0;

  logic                in_stall_o;
  logic                out_valid_o;
  logic                out_send_ready_o;
  logic [1:0]          out_lamp_o;
  logic                out_motor_stop_o;
  logic                out_buzz_level_o;
  logic [DataW-1:0]    out_servo_position_o;
  logic [2:0]          out_phase_now_o;

  int unsigned results_due;
  int unsigned mismatches;
  int unsigned items_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;

  // register values in force, used only to aim the stimulus
  cfg_t plan;

  // opening script: {cmd, byte}, run under trip 1 and release 2
  logic [8:0] opening [25] = '{
    {CMD_TICK, 8'hA5},                             // tick while idle: ignored
    {CMD_BYTE, 8'h00},                             // not the ready code: ignored
    {CMD_BYTE, READY_CODE}, {CMD_BYTE, 8'd0},      // green, lowest temperature
    {CMD_BYTE, READY_CODE}, {CMD_BYTE, 8'd39},     // yellow, top of band
    {CMD_BYTE, READY_CODE}, {CMD_BYTE, 8'd50},     // red, top of band
    {CMD_BYTE, 8'hFE},                             // stray byte before the flag
    {CMD_TICK, 8'h5A},                             // tick outside emergency
    {CMD_BYTE, READY_CODE}, {CMD_BYTE, STOP_CODE}, // flag stops the motor
    {CMD_BYTE, READY_CODE}, {CMD_BYTE, 8'd40},
    {CMD_BYTE, READY_CODE}, {CMD_BYTE, 8'd2},      // flag other than one
    {CMD_BYTE, READY_CODE}, {CMD_BYTE, 8'hFF},     // above red: emergency
    {CMD_BYTE, READY_CODE}, {CMD_BYTE, 8'd51},     // still hot, count below trip
    {CMD_TICK, 8'hFF},
    {CMD_BYTE, READY_CODE}, {CMD_BYTE, 8'd20},     // trip, lamp stays red, hold
    {CMD_BYTE, READY_CODE},                        // bytes during hold: ignored
    {CMD_TICK, 8'h00}                              // count reaches release
  };

  thermal_alarm_sequencer_top #(
    .TICK_BITS(TickBits)
  ) dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .in_cmd_i             (in_cmd_i),
    .in_rx_byte_i         (in_rx_byte_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_send_ready_o     (out_send_ready_o),
    .out_lamp_o           (out_lamp_o),
    .out_motor_stop_o     (out_motor_stop_o),
    .out_buzz_level_o     (out_buzz_level_o),
    .out_servo_position_o (out_servo_position_o),
    .out_phase_now_o      (out_phase_now_o)
  );

  tas_result_checker #(
    .TICK_BITS(TickBits)
  ) checker_i (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_stall_i           (in_stall_o),
    .in_cmd_i             (in_cmd_i),
    .in_rx_byte_i         (in_rx_byte_i),
    .out_valid_i          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_send_ready_i     (out_send_ready_o),
    .out_lamp_i           (out_lamp_o),
    .out_motor_stop_i     (out_motor_stop_o),
    .out_buzz_level_i     (out_buzz_level_o),
    .out_servo_position_i (out_servo_position_o),
    .out_phase_now_i      (out_phase_now_o),
    .results_due_o        (results_due),
    .mismatches_o         (mismatches)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: stall at random, decided at the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99, 0) < recv_stall_pct);
  end

  // Watchdog: drop the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item at a falling edge and hold it until it is taken. Valid is
  // touched once per falling edge, so a back-to-back item never toggles it.
  task automatic put_event(input logic cmd, input logic [DataW-1:0] b);
    @(negedge clk_i);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_cmd_i     <= cmd;
    in_rx_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    // rotate the gap pattern: none, sender, receiver, both
    case ((items_sent / 64) % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
      default: begin send_idle_pct = 19; recv_stall_pct = 19; end
    endcase
  endtask

  task automatic park_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic poke(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
  endtask

  // Drain every result, let the pipeline settle, then write the whole bank.
  task automatic load_settings(input cfg_t c);
    park_input();
    while (results_due != 0) @(posedge clk_i);
    repeat (CfgSettle) @(posedge clk_i);
    plan = c;
    poke(CFG_GREEN_BELOW,   c.green_below);
    poke(CFG_YELLOW_BELOW,  c.yellow_below);
    poke(CFG_RED_MAX,       c.red_max);
    poke(CFG_TRIP_TICKS,    c.trip_ticks);
    poke(CFG_RELEASE_TICKS, c.release_ticks);
    poke(CFG_SERVO_REST,    c.servo_rest);
    poke(CFG_SERVO_TRIP,    c.servo_trip);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic cfg_t random_settings();
    cfg_t c;
    c.green_below   = 8'($urandom_range(60, 0));
    c.yellow_below  = c.green_below + 8'($urandom_range(60, 0));
    c.red_max       = c.yellow_below + 8'($urandom_range(60, 0));
    c.trip_ticks    = 8'($urandom_range(10, 0));
    c.release_ticks = 8'($urandom_range(15, 0));
    c.servo_rest    = 8'($urandom);
    c.servo_trip    = 8'($urandom);
    return c;
  endfunction

  // temperature above the red band, or the top value when there is none
  function automatic logic [DataW-1:0] hot_temp();
    if (plan.red_max == 8'hFF) return 8'hFF;
    return 8'($urandom_range(255, plan.red_max + 1));
  endfunction

  // temperature mostly at or below the red band, often right on a threshold
  function automatic logic [DataW-1:0] mild_temp();
    case ($urandom_range(3, 0))
      0: return 8'($urandom_range(plan.red_max, 0));
      1: return plan.green_below - 8'($urandom_range(1, 0));
      2: return plan.yellow_below - 8'($urandom_range(1, 0));
      default: return plan.red_max;
    endcase
  endfunction

  task automatic noise_burst();
    repeat ($urandom_range(4, 1)) begin
      put_event(1'($urandom_range(1, 0)),
                ($urandom_range(3, 0) == 0) ? READY_CODE : 8'($urandom));
    end
  endtask

  // One reading; in the red band follow with the stop-flag handshake.
  task automatic reading_episode();
    logic [DataW-1:0] t;
    put_event(CMD_BYTE, READY_CODE);
    t = mild_temp();
    put_event(CMD_BYTE, t);
    if (t >= plan.green_below && t >= plan.yellow_below && t <= plan.red_max) begin
      if ($urandom_range(3, 0) == 0) put_event(1'($urandom_range(1, 0)), 8'($urandom));
      put_event(CMD_BYTE, READY_CODE);
      case ($urandom_range(3, 0))
        0, 1: put_event(CMD_BYTE, STOP_CODE);
        2: put_event(CMD_BYTE, 8'd0);
        default: put_event(CMD_BYTE, 8'($urandom));
      endcase
    end
  endtask

  // Enter the emergency, repeat hot readings with ticks between them, then
  // tick on through a possible hold while stray bytes arrive.
  task automatic emergency_episode();
    int unsigned tick_cap;
    int unsigned tail;
    tick_cap = (plan.trip_ticks / 2 + 2 > 20) ? 20 : plan.trip_ticks / 2 + 2;
    tail     = (plan.release_ticks + 2 > 40) ? 40 : plan.release_ticks + 2;
    put_event(CMD_BYTE, READY_CODE);
    put_event(CMD_BYTE, hot_temp());
    repeat ($urandom_range(4, 1)) begin
      repeat ($urandom_range(tick_cap, 0)) put_event(CMD_TICK, 8'($urandom));
      if ($urandom_range(4, 0) == 0) put_event(CMD_BYTE, 8'($urandom_range(255, 2)));
      put_event(CMD_BYTE, READY_CODE);
      put_event(CMD_BYTE, ($urandom_range(6, 0) == 0) ? mild_temp() : hot_temp());
    end
    repeat (tail) begin
      if ($urandom_range(3, 0) == 0) put_event(CMD_BYTE, 8'($urandom));
      put_event(CMD_TICK, 8'($urandom));
    end
  endtask

  // Long counts: saturate the tick counter, trip with an immediate release,
  // then trip again short of release and tick out of the hold.
  task automatic long_count_episode();
    put_event(CMD_BYTE, READY_CODE);
    put_event(CMD_BYTE, hot_temp());
    repeat (300) put_event(CMD_TICK, 8'($urandom));
    put_event(CMD_BYTE, READY_CODE);
    put_event(CMD_BYTE, hot_temp());
    put_event(CMD_BYTE, READY_CODE);
    put_event(CMD_BYTE, hot_temp());
    repeat (plan.trip_ticks + 10) put_event(CMD_TICK, 8'($urandom));
    put_event(CMD_BYTE, READY_CODE);
    put_event(CMD_BYTE, hot_temp());
    repeat (50) begin
      put_event(CMD_BYTE, 8'($urandom));
      put_event(CMD_TICK, 8'($urandom));
    end
  endtask

  initial begin
    cfg_t        c;
    int unsigned phase_start;
    int unsigned pick;

    // hold reset, then release it away from the rising edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // short trip and release so the opening script reaches the hold
    load_settings('{green_below: RST_GREEN_BELOW, yellow_below: RST_YELLOW_BELOW,
                    red_max: RST_RED_MAX, trip_ticks: 8'd1, release_ticks: 8'd2,
                    servo_rest: RST_SERVO_REST, servo_trip: RST_SERVO_TRIP});
    foreach (opening[i]) put_event(opening[i][8], opening[i][7:0]);

    for (int unsigned k = 0; items_sent < ItemGoal; k++) begin
      case (k)
        // all thresholds at zero: every nonzero reading is hot, trip and release at once
        0: c = '{green_below: 8'h00, yellow_below: 8'h00, red_max: 8'h00,
                 trip_ticks: 8'h00, release_ticks: 8'h00,
                 servo_rest: 8'h00, servo_trip: 8'hFF};
        // all at the top: no emergency can start
        1: c = '{green_below: 8'hFF, yellow_below: 8'hFF, red_max: 8'hFF,
                 trip_ticks: 8'hFF, release_ticks: 8'hFF,
                 servo_rest: 8'hFF, servo_trip: 8'h00};
        // late trip and release at the counter's ceiling
        2: c = '{green_below: 8'd10, yellow_below: 8'd20, red_max: 8'd30,
                 trip_ticks: 8'd200, release_ticks: 8'hFF,
                 servo_rest: 8'($urandom), servo_trip: 8'($urandom)};
        default: c = random_settings();
      endcase
      load_settings(c);
      if (k == 2) long_count_episode();
      phase_start = items_sent;
      while (items_sent < phase_start + PhaseItems) begin
        pick = $urandom_range(99, 0);
        if (pick < 15) noise_burst();
        else if (pick < 50) reading_episode();
        else emergency_episode();
      end
    end

    // wait out every result, then watch a little longer for strays
    park_input();
    while (results_due != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
